@@ rtl/core/lwu_pkg.sv @@
// Shared types and constants for the LEDBAT window update block.
// No dependencies; the top level imports this package, the divider does not.
`timescale 1ns / 1ps

package lwu_pkg;

    // Field widths fixed by the interface.
    localparam int WIN_W   = 32;
    localparam int DELAY_W = 20;
    localparam int ACKED_W = 18;
    localparam int MSS_W   = 16;
    localparam int TGT_W   = 16;
    localparam int NIB_W   = 4;

    // Widths of the delay-based update arithmetic.
    // Numerator: gain (4) * offset (20) * acked (18) * segment size (16).
    localparam int PROD_W = NIB_W + DELAY_W + ACKED_W + MSS_W;
    // Denominator: target (16) * window (32).
    localparam int DEN_W  = TGT_W + WIN_W;
    // Signed new window before clamping.
    localparam int NW_W   = PROD_W + 2;

    // Shift-add step counts for the three multiplier passes.
    localparam int STEP_CNT_W = 5;
    localparam int ACK_STEPS  = ACKED_W;
    localparam int MSS_STEPS  = MSS_W;
    localparam int GAIN_STEPS = NIB_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW_SEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_SEG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [TGT_W-1:0] RST_TARGET_DELAY   = 16'd50;
    localparam logic [NIB_W-1:0] RST_GAIN           = 4'd5;
    localparam logic [NIB_W-1:0] RST_MIN_WINDOW_SEG = 4'd2;
    localparam logic [NIB_W-1:0] RST_ALLOWED_SEG    = 4'd1;
    localparam logic [WIN_W-1:0] RST_INITIAL_WINDOW = 32'd4380;

    // One acknowledgement.
    typedef struct packed {
        logic               new_measurement;
        logic [DELAY_W-1:0] sample_delay;
        logic [DELAY_W-1:0] base_delay;
        logic [ACKED_W-1:0] bytes_acked;
        logic [MSS_W-1:0]   segment_size;
        logic [WIN_W-1:0]   flight_bytes;
        logic [WIN_W-1:0]   slow_start_threshold;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic               in_slow_start;
        logic [DELAY_W-1:0] queuing_delay;
        logic               window_changed;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SETUP,
        S_MUL_ACK,
        S_MUL_MSS,
        S_MUL_GAIN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_APPLY,
        S_CLAMP,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/ledbat_window_update.sv @@
// LEDBAT congestion window update, top level: sequencer, shift-add multiplier
// and result register. Depends on lwu_pkg and lwu_serial_div.
`timescale 1ns / 1ps

// The block takes one acknowledgement at a time and returns one result per
// acknowledgement. A slow start step or an acknowledgement without a usable
// delay sample is decoded and goes straight to the hand-over state; the next
// acknowledgement is taken once the result is handed over.
// A delay-based update runs decode and setup, 38 steps of a bit-serial
// shift-add multiplier (one pass each over bytes acked, segment size and gain,
// with the target times window divisor formed alongside the first pass), a
// divider start and 58 steps of a one-bit-per-cycle restoring divider, then
// sees it finish, applies the change, clamps and hands over the result. A
// stalled result that still fills the output register holds the finished
// item back in its hand-over state.
// The input is stalled while an acknowledgement is in work; a finished result
// waits in the output register while the next acknowledgement is taken.
// Configuration writes are always ready and must only be issued while the
// block is idle. Writing the initial window also loads the live window, with
// zero loaded as one. A zero target delay is used as one.

module ledbat_window_update
    import lwu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Acknowledgement channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [TGT_W-1:0]    r_target_delay, n_target_delay;
    logic [NIB_W-1:0]    r_gain, n_gain;
    logic [NIB_W-1:0]    r_min_seg, n_min_seg;
    logic [NIB_W-1:0]    r_allow_seg, n_allow_seg;

    // Window state.
    logic [WIN_W-1:0]    r_cwnd, n_cwnd;
    logic                r_slow_start, n_slow_start;

    // Sequencer and working registers.
    t_state              r_state, n_state;
    t_in_item            r_item, n_item;
    logic [DELAY_W-1:0]  r_qd, n_qd;
    logic [TGT_W-1:0]    r_tgt, n_tgt;
    logic                r_neg, n_neg;
    logic                r_changed, n_changed;
    logic [WIN_W-1:0]    r_cap, n_cap;
    logic [DELAY_W-1:0]  r_floor, n_floor;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [PROD_W-1:0]   r_mcand, n_mcand;
    logic [ACKED_W-1:0]  r_mplier, n_mplier;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [DEN_W-1:0]    r_dcand, n_dcand;
    logic [TGT_W-1:0]    r_dplier, n_dplier;
    logic [DEN_W-1:0]    r_dacc, n_dacc;
    logic signed [NW_W-1:0] r_nw, n_nw;

    // Result register.
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // Divider interface.
    logic                div_start;
    logic                div_done;
    logic [PROD_W-1:0]   div_quot;

    // Helper terms.
    logic [DELAY_W-1:0]  qd_c;
    logic [WIN_W:0]      ss_sum;
    logic [WIN_W-1:0]    ss_win;
    logic [DELAY_W-1:0]  tgt_ext;
    logic                neg_c;
    logic [DELAY_W-1:0]  off_c;
    logic [DELAY_W-1:0]  allow_bytes;
    logic [WIN_W:0]      cap_sum;
    logic [PROD_W-1:0]   mul_sum;
    logic [DEN_W-1:0]    den_sum;
    logic [NW_W-1:0]     win_ext;
    logic [NW_W-1:0]     mag_ext;
    logic signed [NW_W-1:0] cap_s, floor_s, clamp_hi, clamp_lo, clamp_one;
    logic                out_free;

    function automatic logic [WIN_W-1:0] at_least_one(input logic [WIN_W-1:0] v);
        return (v == '0) ? WIN_W'(1) : v;
    endfunction

    lwu_serial_div #(
        .P_NUM_W (PROD_W),
        .P_DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_dacc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Arithmetic shared by the sequencer states.
    always_comb begin
        // Queue delay, floored at zero.
        qd_c = (r_item.sample_delay > r_item.base_delay)
             ? (r_item.sample_delay - r_item.base_delay) : '0;

        // Slow start growth by one segment, saturating.
        ss_sum = {1'b0, r_cwnd} + (WIN_W + 1)'(r_item.segment_size);
        ss_win = at_least_one(ss_sum[WIN_W] ? '1 : ss_sum[WIN_W-1:0]);

        // Off-target magnitude and direction.
        tgt_ext = DELAY_W'(r_tgt);
        neg_c   = (r_qd > tgt_ext);
        off_c   = neg_c ? (r_qd - tgt_ext) : (tgt_ext - r_qd);

        // Upper bound: flight plus allowed segments, saturating.
        allow_bytes = DELAY_W'(r_allow_seg) * DELAY_W'(r_item.segment_size);
        cap_sum     = {1'b0, r_item.flight_bytes} + (WIN_W + 1)'(allow_bytes);

        // One shift-add step of each multiplier.
        mul_sum = r_acc + (r_mplier[0] ? r_mcand : '0);
        den_sum = r_dacc + (r_dplier[0] ? r_dcand : '0);

        // Apply the signed change to the window.
        win_ext = NW_W'(r_cwnd);
        mag_ext = NW_W'(div_quot);

        // Clamp: cap first, then the floor, then never below one.
        cap_s     = $signed(NW_W'(r_cap));
        floor_s   = $signed(NW_W'(r_floor));
        clamp_hi  = (r_nw > cap_s) ? cap_s : r_nw;
        clamp_lo  = (clamp_hi < floor_s) ? floor_s : clamp_hi;
        clamp_one = (clamp_lo < $signed(NW_W'(1))) ? $signed(NW_W'(1)) : clamp_lo;

        // The result register can take a new result.
        out_free = !r_out_valid || !i_out_stall;
    end

    // Sequencer, next state and datapath loads.
    always_comb begin
        n_state        = r_state;
        n_item         = r_item;
        n_qd           = r_qd;
        n_tgt          = r_tgt;
        n_neg          = r_neg;
        n_changed      = r_changed;
        n_cap          = r_cap;
        n_floor        = r_floor;
        n_cnt          = r_cnt;
        n_mcand        = r_mcand;
        n_mplier       = r_mplier;
        n_acc          = r_acc;
        n_dcand        = r_dcand;
        n_dplier       = r_dplier;
        n_dacc         = r_dacc;
        n_nw           = r_nw;
        n_cwnd         = r_cwnd;
        n_slow_start   = r_slow_start;
        n_out          = r_out;
        n_out_valid    = r_out_valid && i_out_stall;
        n_target_delay = r_target_delay;
        n_gain         = r_gain;
        n_min_seg      = r_min_seg;
        n_allow_seg    = r_allow_seg;
        div_start      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_PREP;
                end
            end

            // Decide which kind of step this acknowledgement is.
            S_PREP: begin
                n_qd = qd_c;
                if (r_slow_start) begin
                    n_cwnd       = ss_win;
                    n_slow_start = !(ss_win > r_item.slow_start_threshold);
                    n_changed    = 1'b1;
                    n_state      = S_DONE;
                end else if (r_item.new_measurement && (r_item.sample_delay != '0)
                             && (r_item.base_delay != '0)) begin
                    n_tgt   = (r_target_delay == '0) ? TGT_W'(1) : r_target_delay;
                    n_state = S_SETUP;
                end else begin
                    n_changed = 1'b0;
                    n_state   = S_DONE;
                end
            end

            // Load the multipliers and the clamp bounds.
            S_SETUP: begin
                n_neg    = neg_c;
                n_mcand  = PROD_W'(off_c);
                n_mplier = r_item.bytes_acked;
                n_acc    = '0;
                n_dcand  = DEN_W'(r_cwnd);
                n_dplier = r_tgt;
                n_dacc   = '0;
                n_cnt    = STEP_CNT_W'(ACK_STEPS - 1);
                n_cap    = cap_sum[WIN_W] ? '1 : cap_sum[WIN_W-1:0];
                n_floor  = DELAY_W'(r_min_seg) * DELAY_W'(r_item.segment_size);
                n_state  = S_MUL_ACK;
            end

            // Offset times bytes acked; target times window runs alongside.
            S_MUL_ACK: begin
                n_dacc   = den_sum;
                n_dcand  = r_dcand << 1;
                n_dplier = r_dplier >> 1;
                n_cnt    = r_cnt - STEP_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_mcand  = mul_sum;
                    n_acc    = '0;
                    n_mplier = ACKED_W'(r_item.segment_size);
                    n_cnt    = STEP_CNT_W'(MSS_STEPS - 1);
                    n_state  = S_MUL_MSS;
                end else begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end

            // Running product times segment size.
            S_MUL_MSS: begin
                n_cnt = r_cnt - STEP_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_mcand  = mul_sum;
                    n_acc    = '0;
                    n_mplier = ACKED_W'(r_gain);
                    n_cnt    = STEP_CNT_W'(GAIN_STEPS - 1);
                    n_state  = S_MUL_GAIN;
                end else begin
                    n_acc    = mul_sum;
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end

            // Running product times gain; the accumulator keeps the numerator.
            S_MUL_GAIN: begin
                n_acc    = mul_sum;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - STEP_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_DIV_GO;
                end
            end

            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end

            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_APPLY;
                end
            end

            S_APPLY: begin
                n_nw    = r_neg ? $signed(win_ext - mag_ext) : $signed(win_ext + mag_ext);
                n_state = S_CLAMP;
            end

            S_CLAMP: begin
                n_cwnd    = clamp_one[WIN_W-1:0];
                n_changed = 1'b1;
                n_state   = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (out_free) begin
                    n_out.window         = r_cwnd;
                    n_out.in_slow_start  = r_slow_start;
                    n_out.queuing_delay  = r_qd;
                    n_out.window_changed = r_changed;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Configuration write transfer.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARGET_DELAY:   n_target_delay = i_cfg_data[TGT_W-1:0];
                CFG_GAIN:           n_gain         = i_cfg_data[NIB_W-1:0];
                CFG_MIN_WINDOW_SEG: n_min_seg      = i_cfg_data[NIB_W-1:0];
                CFG_ALLOWED_SEG:    n_allow_seg    = i_cfg_data[NIB_W-1:0];
                CFG_INITIAL_WINDOW: n_cwnd         = at_least_one(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Control and state registers reset; working payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_cwnd         <= RST_INITIAL_WINDOW;
            r_slow_start   <= 1'b1;
            r_target_delay <= RST_TARGET_DELAY;
            r_gain         <= RST_GAIN;
            r_min_seg      <= RST_MIN_WINDOW_SEG;
            r_allow_seg    <= RST_ALLOWED_SEG;
            r_cnt          <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_cwnd         <= n_cwnd;
            r_slow_start   <= n_slow_start;
            r_target_delay <= n_target_delay;
            r_gain         <= n_gain;
            r_min_seg      <= n_min_seg;
            r_allow_seg    <= n_allow_seg;
            r_cnt          <= n_cnt;
        end
        r_item    <= n_item;
        r_qd      <= n_qd;
        r_tgt     <= n_tgt;
        r_neg     <= n_neg;
        r_changed <= n_changed;
        r_cap     <= n_cap;
        r_floor   <= n_floor;
        r_mcand   <= n_mcand;
        r_mplier  <= n_mplier;
        r_acc     <= n_acc;
        r_dcand   <= n_dcand;
        r_dplier  <= n_dplier;
        r_dacc    <= n_dacc;
        r_nw      <= n_nw;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ rtl/core/lwu_serial_div.sv @@
// Restoring divider that produces one quotient bit per clock cycle.
// Depends on nothing but its parameters; used by ledbat_window_update.
`timescale 1ns / 1ps

module lwu_serial_div #(
    parameter int P_NUM_W = 58,
    parameter int P_DEN_W = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [P_NUM_W-1:0] i_num,
    input  logic [P_DEN_W-1:0] i_den,
    output logic               o_done,
    output logic [P_NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(P_NUM_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [P_NUM_W-1:0] r_quot, n_quot;
    logic [P_DEN_W-1:0] r_rem, n_rem;
    logic [P_DEN_W-1:0] r_den, n_den;

    logic [P_DEN_W:0]   rem_sh;
    logic [P_DEN_W:0]   rem_diff;
    logic               fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb begin
        rem_sh   = {r_rem, r_quot[P_NUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        fits     = (rem_sh >= {1'b0, r_den});
    end

    // Step control. The dividend register doubles as the quotient register.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(P_NUM_W);
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_quot = {r_quot[P_NUM_W-2:0], fits};
            n_rem  = fits ? rem_diff[P_DEN_W-1:0] : rem_sh[P_DEN_W-1:0];
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ verif/lwu_checker.sv @@
// Scoreboard for the LEDBAT window update block: tracks register writes,
// predicts one result per acknowledgement and compares the result stream.
// Depends on lwu_pkg for the item types, widths and register indexes.
`timescale 1ns / 1ps

module lwu_checker
    import lwu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [63:0] WIN_SAT = 64'hFFFF_FFFF;

    // Shadow copies of the registers and of the window state.
    logic [TGT_W-1:0] target_delay;
    logic [NIB_W-1:0] gain;
    logic [NIB_W-1:0] min_window_seg;
    logic [NIB_W-1:0] allowed_seg;
    logic [WIN_W-1:0] cwnd;
    logic             slow_start;

    t_out_item window_results[$];
    int        mismatches;

    function automatic logic [WIN_W-1:0] at_least_one(input logic [WIN_W-1:0] v);
        return (v == '0) ? 32'd1 : v;
    endfunction

    // Applies one acknowledgement to the shadow window and returns the result.
    function automatic t_out_item update_window(input t_in_item ack);
        logic [DELAY_W-1:0] qd;
        logic [63:0]        grown;
        logic [63:0]        tgt;
        logic [63:0]        win;
        logic [63:0]        off;
        logic [63:0]        mag;
        logic [63:0]        cap;
        logic [63:0]        floor_v;
        logic               shrink;
        longint             nw;
        logic               changed;
        t_out_item          r;
        qd = (ack.sample_delay > ack.base_delay) ? ack.sample_delay - ack.base_delay : '0;
        changed = 1'b0;
        if (slow_start) begin
            // One segment per acknowledgement, saturating at the window width.
            grown = 64'(cwnd) + 64'(ack.segment_size);
            if (grown > WIN_SAT) begin
                grown = WIN_SAT;
            end
            cwnd = at_least_one(grown[WIN_W-1:0]);
            if (cwnd > ack.slow_start_threshold) begin
                slow_start = 1'b0;
            end
            changed = 1'b1;
        end else if (ack.new_measurement && ack.sample_delay != '0 && ack.base_delay != '0) begin
            // Delay-based step, then cap above flight and floor at the minimum.
            tgt = 64'(at_least_one(32'(target_delay)));
            win = 64'(at_least_one(cwnd));
            shrink = 64'(qd) > tgt;
            off = shrink ? 64'(qd) - tgt : tgt - 64'(qd);
            mag = (64'(gain) * off * 64'(ack.bytes_acked) * 64'(ack.segment_size)) / (tgt * win);
            nw = shrink ? longint'(win) - longint'(mag) : longint'(win) + longint'(mag);
            cap = 64'(ack.flight_bytes) + 64'(allowed_seg) * 64'(ack.segment_size);
            if (cap > WIN_SAT) begin
                cap = WIN_SAT;
            end
            floor_v = 64'(min_window_seg) * 64'(ack.segment_size);
            if (nw > longint'(cap)) begin
                nw = longint'(cap);
            end
            if (nw < longint'(floor_v)) begin
                nw = longint'(floor_v);
            end
            if (nw < 1) begin
                nw = 1;
            end
            cwnd = nw[WIN_W-1:0];
            changed = 1'b1;
        end
        r.window = cwnd;
        r.in_slow_start = slow_start;
        r.queuing_delay = qd;
        r.window_changed = changed;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            target_delay = RST_TARGET_DELAY;
            gain = RST_GAIN;
            min_window_seg = RST_MIN_WINDOW_SEG;
            allowed_seg = RST_ALLOWED_SEG;
            cwnd = RST_INITIAL_WINDOW;
            slow_start = 1'b1;
            window_results.delete();
            mismatches = 0;
        end else begin
            // Register write transfers.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET_DELAY:   target_delay = i_cfg_data[TGT_W-1:0];
                    CFG_GAIN:           gain = i_cfg_data[NIB_W-1:0];
                    CFG_MIN_WINDOW_SEG: min_window_seg = i_cfg_data[NIB_W-1:0];
                    CFG_ALLOWED_SEG:    allowed_seg = i_cfg_data[NIB_W-1:0];
                    CFG_INITIAL_WINDOW: cwnd = at_least_one(i_cfg_data);
                    default: ;
                endcase
            end

            // Result transfers are matched against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (window_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result with none pending: window=%0d ss=%0b qd=%0d chg=%0b",
                                 $realtime, i_out_data.window, i_out_data.in_slow_start,
                                 i_out_data.queuing_delay, i_out_data.window_changed);
                    end
                    mismatches++;
                end else begin
                    want = window_results.pop_front();
                    if (i_out_data.window !== want.window
                            || i_out_data.in_slow_start !== want.in_slow_start
                            || i_out_data.queuing_delay !== want.queuing_delay
                            || i_out_data.window_changed !== want.window_changed) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch exp window=%0d ss=%0b qd=%0d chg=%0b",
                                     $realtime, want.window, want.in_slow_start,
                                     want.queuing_delay, want.window_changed);
                            $display("%0t:          got window=%0d ss=%0b qd=%0d chg=%0b",
                                     $realtime, i_out_data.window, i_out_data.in_slow_start,
                                     i_out_data.queuing_delay, i_out_data.window_changed);
                        end
                        mismatches++;
                    end
                end
            end

            // Acknowledgement transfers produce one prediction each.
            if (i_in_valid && !i_in_stall) begin
                window_results.push_back(update_window(i_in_data));
            end
        end
        o_fail_count <= mismatches;
        o_pending <= window_results.size();
    end

endmodule

@@ verif/tb_ledbat_window_update.sv @@
// Top of the LEDBAT window update testbench: clock, reset, acknowledgement
// and register traffic, receiver stalls, watchdog and verdict.
// Depends on lwu_pkg, ledbat_window_update and lwu_checker.
`timescale 1ns / 1ps

module tb_ledbat_window_update
    import lwu_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES = 12;
    localparam int ACKS_PER_PHASE = 135;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [WIN_W-1:0] WIN_MAX = '1;
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
    localparam logic [ACKED_W-1:0] ACKED_MAX = '1;
    localparam logic [MSS_W-1:0] MSS_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_armed = 1'b0;
    int unsigned cur_target = 50;

    ledbat_window_update uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lwu_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int   hold_left = 0;
    logic hold_taken = 1'b0;

    // Receiver: random stalls, plus one long hold-off once armed.
    always @(posedge clk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random value with a random number of low bits in use.
    function automatic logic [31:0] rand_bits(input int unsigned width);
        int unsigned k;
        k = $urandom_range(1, width);
        return $urandom & (32'hFFFF_FFFF >> (32 - k));
    endfunction

    function automatic t_in_item make_ack(input logic meas, input logic [DELAY_W-1:0] sample,
                                          input logic [DELAY_W-1:0] base,
                                          input logic [ACKED_W-1:0] acked,
                                          input logic [MSS_W-1:0] mss,
                                          input logic [WIN_W-1:0] flight,
                                          input logic [WIN_W-1:0] ssthresh);
        t_in_item a;
        a.new_measurement = meas;
        a.sample_delay = sample;
        a.base_delay = base;
        a.bytes_acked = acked;
        a.segment_size = mss;
        a.flight_bytes = flight;
        a.slow_start_threshold = ssthresh;
        return a;
    endfunction

    // Mostly plausible acknowledgements with delays around the target, some noise.
    function automatic t_in_item random_ack();
        t_in_item    a;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        a = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if (pick < 92) begin
            a.new_measurement = (pick < 80);
            a.segment_size = ($urandom_range(0, 9) == 0) ? MSS_W'(rand_bits(MSS_W))
                                                        : MSS_W'($urandom_range(500, 1500));
            a.base_delay = ($urandom_range(0, 3) == 0) ? DELAY_W'(rand_bits(DELAY_W))
                                                      : DELAY_W'($urandom_range(1, 2000));
            if (pick < 70) begin
                a.sample_delay = a.base_delay + DELAY_W'($urandom_range(0, 2 * cur_target + 2));
            end else begin
                a.sample_delay = DELAY_W'(rand_bits(DELAY_W));
            end
            a.bytes_acked = ($urandom_range(0, 3) == 0)
                            ? ACKED_W'(rand_bits(ACKED_W))
                            : ACKED_W'($urandom_range(1, 4) * a.segment_size);
            a.flight_bytes = ($urandom_range(0, 3) == 0) ? rand_bits(WIN_W)
                                                        : $urandom_range(0, 200000);
            a.slow_start_threshold = rand_bits(WIN_W);
        end
        return a;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all registers; unused upper data bits carry random junk.
    task automatic set_config(input logic [TGT_W-1:0] target, input logic [NIB_W-1:0] g,
                              input logic [NIB_W-1:0] min_seg,
                              input logic [NIB_W-1:0] allowed,
                              input logic [WIN_W-1:0] init_win);
        write_reg(CFG_TARGET_DELAY, {16'($urandom), target});
        write_reg(CFG_GAIN, {28'($urandom), g});
        write_reg(CFG_MIN_WINDOW_SEG, {28'($urandom), min_seg});
        write_reg(CFG_ALLOWED_SEG, {28'($urandom), allowed});
        write_reg(CFG_INITIAL_WINDOW, init_win);
        cfg_valid <= 1'b0;
        cur_target = (target == '0) ? 1 : target;
    endtask

    // One acknowledgement transfer, with an optional idle gap before it.
    task automatic send_ack(input t_in_item a);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= a;
        do @(posedge clk); while (in_stall);
    endtask

    // Waits until every predicted result has been transferred.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Slow start: growth, zero segment, saturation, and its end.
        send_ack(make_ack(1'b0, 20'd0, 20'd0, 18'd1460, 16'd1460, 32'd0, WIN_MAX));
        send_ack(make_ack(1'b1, 20'd10, 20'd5, 18'd0, 16'd0, WIN_MAX, WIN_MAX));
        drain();
        write_reg(CFG_INITIAL_WINDOW, 32'hFFFF_FF00);
        cfg_valid <= 1'b0;
        send_ack(make_ack(1'b1, DELAY_MAX, 20'd1, ACKED_MAX, MSS_MAX, WIN_MAX, WIN_MAX));
        drain();
        write_reg(CFG_INITIAL_WINDOW, 32'd0);
        cfg_valid <= 1'b0;
        send_ack(make_ack(1'b1, DELAY_MAX, DELAY_MAX, ACKED_MAX, 16'd0, WIN_MAX, 32'd0));
        drain();
        write_reg(CFG_INITIAL_WINDOW, 32'd30000);
        cfg_valid <= 1'b0;

        // Delay-based steps with the reset settings.
        send_ack(make_ack(1'b0, DELAY_MAX, 20'd1, ACKED_MAX, MSS_MAX, WIN_MAX, WIN_MAX));
        send_ack(make_ack(1'b1, 20'd0, 20'd100, 18'd1460, 16'd1460, 32'd100000, 32'd0));
        send_ack(make_ack(1'b1, 20'd100, 20'd0, 18'd1460, 16'd1460, 32'd100000, 32'd0));
        send_ack(make_ack(1'b1, 20'd120, 20'd100, 18'd1460, 16'd1460, 32'd100000, 32'd0));
        send_ack(make_ack(1'b1, 20'd1000, 20'd100, 18'd1460, 16'd1460, 32'd100000, 32'd0));
        send_ack(make_ack(1'b1, 20'd150, 20'd100, 18'd2920, 16'd1460, 32'd100000, 32'd0));
        send_ack(make_ack(1'b1, 20'd50, 20'd100, 18'd1460, 16'd1460, 32'd100000, 32'd0));
        // Cap overflow, floor above cap, zero segment size, deep decrease.
        send_ack(make_ack(1'b1, 20'd1, DELAY_MAX, ACKED_MAX, MSS_MAX, WIN_MAX, 32'd0));
        send_ack(make_ack(1'b1, 20'd120, 20'd100, 18'd1460, 16'd1460, 32'd0, 32'd0));
        send_ack(make_ack(1'b1, 20'd120, 20'd100, 18'd1460, 16'd0, 32'd0, 32'd0));
        send_ack(make_ack(1'b1, DELAY_MAX, 20'd1, ACKED_MAX, MSS_MAX, WIN_MAX, WIN_MAX));
        drain();

        // Zero target and the largest gain and segment counts.
        set_config(16'd0, 4'd15, 4'd15, 4'd15, 32'd1000);
        send_ack(make_ack(1'b1, 20'd7, 20'd7, ACKED_MAX, MSS_MAX, WIN_MAX, 32'd0));
        send_ack(make_ack(1'b1, DELAY_MAX, 20'd1, ACKED_MAX, MSS_MAX, 32'd5000, 32'd0));
        send_ack(make_ack(1'b1, 20'd3, 20'd3, ACKED_MAX, MSS_MAX, 32'd123456, 32'd0));
        drain();

        // Largest target, zero gain and zero segment counts.
        set_config(MSS_MAX, 4'd0, 4'd0, 4'd0, WIN_MAX);
        send_ack(make_ack(1'b1, 20'd500, 20'd10, 18'd1000, 16'd1000, 32'd70000, 32'd0));
        send_ack(make_ack(1'b1, 20'd500, 20'd10, 18'd1000, 16'd0, 32'd0, 32'd0));
        drain();
        write_reg(CFG_UNUSED, WIN_MAX);
        cfg_valid <= 1'b0;
        send_ack(make_ack(1'b1, 20'd500, 20'd10, 18'd1000, 16'd1000, 32'd90000, 32'd0));
        drain();

        // Random phases: each idling mode under several register settings.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct = 19;
                    recv_stall_pct = 19;
                end
            endcase
            case (p)
                1: set_config(16'd1, 4'd0, 4'd1, 4'd0, $urandom_range(1, 100000));
                2: set_config(MSS_MAX, 4'd15, 4'd15, 4'd15, WIN_MAX);
                3: set_config(16'd0, 4'd15, 4'd1, 4'd15, 32'd1);
                default: set_config(TGT_W'($urandom_range(10, 500)), NIB_W'($urandom),
                                    NIB_W'($urandom_range(1, 15)), NIB_W'($urandom),
                                    ($urandom_range(0, 1) == 0) ? rand_bits(WIN_W)
                                                               : $urandom_range(1000, 100000));
            endcase
            for (int n = 0; n < ACKS_PER_PHASE; n++) begin
                // Long receiver hold-off while acknowledgements keep coming.
                if (p == 0 && n == 10) begin
                    hold_armed <= 1'b1;
                end
                send_ack(random_ack());
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lwu_pkg.sv
rtl/core/lwu_serial_div.sv
rtl/core/ledbat_window_update.sv
verif/lwu_checker.sv
verif/tb_ledbat_window_update.sv
